### hdl/multichannel_offset_calibrator_defines.svh
// Assertion macros shared by the offset calibrator RTL.
// No dependencies; included by the files that carry assertions.
`ifndef MULTICHANNEL_OFFSET_CALIBRATOR_DEFINES_SVH
`define MULTICHANNEL_OFFSET_CALIBRATOR_DEFINES_SVH

// expression holds at every clock edge outside reset
`define MOC_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define MOC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define MOC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/moc_pkg.sv
// Shared types, widths and codes of the multichannel offset calibrator.
// No dependencies; imported by every module of the block.
`default_nettype none

package moc_pkg;

   // field widths
   localparam int MAX_CHANNELS = 8;
   localparam int SAMPLE_W     = 15;
   localparam int VALUE_W      = 15;
   localparam int TOTAL_W      = 17;
   localparam int OFS_SUM_W    = 22;
   localparam int MAP_SUM_W    = 23;
   localparam int RADIO_W      = 8;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 8;

   // parameter defaults
   localparam int DEF_CHANNELS      = 8;
   localparam int DEF_OFFSET_FRAMES = 100;
   localparam int DEF_MAP_FRAMES    = 500;

   localparam logic [RADIO_W-1:0] RADIO_DIV_RESET = 8'd10;

   // cycles of the divide sequence after the last accumulated frame
   localparam int FIN_STEPS = 4;

   // input action codes
   localparam logic ACT_SAMPLE    = 1'b0;
   localparam logic ACT_MAP_START = 1'b1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [VALUE_W-1:0]         value_type;

   typedef enum logic [1:0] {
      KIND_LOG   = 2'd0,
      KIND_RADIO = 2'd1,
      KIND_MAP   = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LOGGING_ENABLE   = 2'd0,
      REG_STREAMING_ENABLE = 2'd1,
      REG_RADIO_DIVIDER    = 2'd2
   } csr_reg_type;

   // control from the sequencer to every lane
   typedef struct packed {
      logic ofs_acc;   // add sample into offset accumulator
      logic map_acc;   // add clamped sample into map accumulator
      logic map_clr;   // clear map accumulator
      logic div_load;  // latch dividend
      logic div_mult;  // reciprocal multiply
      logic div_done;  // write quotient back
      logic div_map;   // divide sequence serves the map (else the offset)
   } lane_ctrl_type;

   // one result word
   typedef struct packed {
      kind_type                       kind;
      value_type [MAX_CHANNELS-1:0]   value;
      logic [TOTAL_W-1:0]             total;
   } rsp_word_type;

endpackage

`default_nettype wire

### hdl/moc_lane.sv
// One channel lane: offset and weight-map accumulators, reciprocal divider,
// offset subtraction with clamp. Depends on moc_pkg.
`default_nettype none

module moc_lane
   import moc_pkg::*;
#(
   parameter int OFFSET_FRAMES = DEF_OFFSET_FRAMES,
   parameter int MAP_FRAMES    = DEF_MAP_FRAMES
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire lane_ctrl_type ctrl,
   input  wire sample_type    sample,
   output value_type          cal_value,
   output value_type          avg_value
);

   // x / D == (x * M) >> K for all x below 2**N, with M = ceil(2**K / D)
   localparam int OFS_N   = OFS_SUM_W - 1;
   localparam int OFS_K   = OFS_N + $clog2(OFFSET_FRAMES);
   localparam int MAP_K   = MAP_SUM_W + $clog2(MAP_FRAMES);
   localparam int DVD_W   = MAP_SUM_W;
   localparam int MUL_W   = MAP_SUM_W + 1;
   localparam int PROD_W  = DVD_W + MUL_W;
   localparam longint OFS_M_L = ((longint'(1) << OFS_K) + OFFSET_FRAMES - 1) / OFFSET_FRAMES;
   localparam longint MAP_M_L = ((longint'(1) << MAP_K) + MAP_FRAMES - 1) / MAP_FRAMES;
   localparam logic [MUL_W-1:0] OFS_M = MUL_W'(OFS_M_L);
   localparam logic [MUL_W-1:0] MAP_M = MUL_W'(MAP_M_L);

   logic signed [OFS_SUM_W-1:0] ofs_sum_ff, ofs_sum_in;
   logic [MAP_SUM_W-1:0]        map_sum_ff, map_sum_in;
   sample_type                  ofs_ff, ofs_in;
   value_type                   avg_ff, avg_in;
   logic [DVD_W-1:0]            dvd_ff, dvd_in;
   logic                        neg_ff, neg_in;
   logic [PROD_W-1:0]           prod_ff, prod_in;

   logic signed [OFS_SUM_W-1:0] ofs_abs;
   logic [MUL_W-1:0]            mul_sel;
   value_type                   quot;
   logic signed [SAMPLE_W:0]    diff;

   // accumulators
   always_comb begin
      ofs_sum_in = ofs_sum_ff;
      map_sum_in = map_sum_ff;
      if (ctrl.ofs_acc) begin
         ofs_sum_in = ofs_sum_ff + OFS_SUM_W'(sample);
      end
      if (ctrl.map_clr) begin
         map_sum_in = '0;
      end else if (ctrl.map_acc) begin
         // negative samples weigh nothing
         map_sum_in = map_sum_ff + (sample[SAMPLE_W-1] ? '0 : MAP_SUM_W'($unsigned(sample)));
      end
   end

   // divider: load magnitude, multiply, take the quotient bits
   always_comb begin
      ofs_abs = ofs_sum_ff[OFS_SUM_W-1] ? -ofs_sum_ff : ofs_sum_ff;
      mul_sel = ctrl.div_map ? MAP_M : OFS_M;
      quot    = ctrl.div_map ? prod_ff[MAP_K +: VALUE_W] : prod_ff[OFS_K +: VALUE_W];

      dvd_in  = dvd_ff;
      neg_in  = neg_ff;
      prod_in = prod_ff;
      ofs_in  = ofs_ff;
      avg_in  = avg_ff;
      if (ctrl.div_load) begin
         dvd_in = ctrl.div_map ? map_sum_ff : DVD_W'($unsigned(ofs_abs));
         neg_in = !ctrl.div_map && ofs_sum_ff[OFS_SUM_W-1];
      end
      if (ctrl.div_mult) begin
         prod_in = PROD_W'(dvd_ff) * PROD_W'(mul_sel);
      end
      if (ctrl.div_done) begin
         if (ctrl.div_map) begin
            avg_in = quot;
         end else begin
            // truncation toward zero: divide magnitude, restore sign
            ofs_in = neg_ff ? -$signed(quot) : $signed(quot);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ofs_sum_ff <= '0;
         map_sum_ff <= '0;
         ofs_ff     <= '0;
      end else begin
         ofs_sum_ff <= ofs_sum_in;
         map_sum_ff <= map_sum_in;
         ofs_ff     <= ofs_in;
      end
      dvd_ff  <= dvd_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      avg_ff  <= avg_in;
   end

   // calibrated value, clamped at zero
   always_comb begin
      diff      = (SAMPLE_W+1)'(sample) - (SAMPLE_W+1)'(ofs_ff);
      cal_value = diff[SAMPLE_W] ? '0 : diff[VALUE_W-1:0];
   end

   assign avg_value = avg_ff;

endmodule

`default_nettype wire

### hdl/moc_merge.sv
// Merging stage: builds result words from the lanes, totals the map
// averages and holds a two-word output queue. Depends on moc_pkg.
`default_nettype none
`include "multichannel_offset_calibrator_defines.svh"

module moc_merge
   import moc_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         frame_push,
   input  wire kind_type                     frame_kind,
   input  wire value_type [MAX_CHANNELS-1:0] cal_vals,
   input  wire logic                         map_push,
   input  wire value_type [MAX_CHANNELS-1:0] avg_vals,
   output logic                              full,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output rsp_word_type                      rsp_word
);

   rsp_word_type       ent_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   rsp_word_type       push_word;
   logic [TOTAL_W-1:0] total;
   logic               push, pop;

   // total of the map averages
   always_comb begin
      total = '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         total = total + TOTAL_W'(avg_vals[c]);
      end
   end

   // word to enqueue
   always_comb begin
      if (map_push) begin
         push_word.kind  = KIND_MAP;
         push_word.value = avg_vals;
         push_word.total = total;
      end else begin
         push_word.kind  = frame_kind;
         push_word.value = cal_vals;
         push_word.total = '0;
      end
   end

   // queue pointers
   always_comb begin
      push      = frame_push || map_push;
      pop       = rsp_valid && rsp_ready;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_word  = ent_ff[rd_ptr_ff];
   assign full      = (count_ff == 2'd2);

   `MOC_ASSERT_IMPL(a_no_overflow, clock, reset, push, count_ff != 2'd2 || pop, "queue overflow")
   `MOC_ASSERT_ALWAYS(a_one_source, clock, reset, !(frame_push && map_push), "two words at once")
   `MOC_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= 2'd2, "queue count out of range")

endmodule

`default_nettype wire

### hdl/multichannel_offset_calibrator.sv
// Multichannel ADC offset calibrator, top level: sequencer, registers,
// lane array and merging stage. Depends on moc_pkg, moc_lane, moc_merge.
//
// Usage:
//   req_ channel: one word per frame of eight signed samples, or a capture
//   start when req_action is set. rsp_ channel: logger, radio or weight-map
//   words. csr_ channel: register writes (0 logging, 1 streaming, 2 radio
//   divider), always ready, one write per cycle.
//   A frame is accepted every cycle while req_ready is high; a frame that
//   yields a result is written into the output queue, which presents it on
//   rsp_. The first OFFSET_FRAMES frames after reset form the offsets and
//   yield nothing. After the last of them, and after the last frame of a
//   weight-map capture, the lanes run a reciprocal divide (load, multiply,
//   write back) during which req_ready is low; then the weight-map word is queued.
//   Reset clears all accumulators, counters and the output queue and loads the
//   register defaults (radio divider 10).
//   The output queue holds two words; when the receiver stalls it fills and
//   req_ready drops until a word is taken.
`default_nettype none
`include "multichannel_offset_calibrator_defines.svh"

module multichannel_offset_calibrator
   import moc_pkg::*;
#(
   parameter int CHANNELS      = DEF_CHANNELS,
   parameter int OFFSET_FRAMES = DEF_OFFSET_FRAMES,
   parameter int MAP_FRAMES    = DEF_MAP_FRAMES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_action,
   input  wire sample_type             req_sample_0,
   input  wire sample_type             req_sample_1,
   input  wire sample_type             req_sample_2,
   input  wire sample_type             req_sample_3,
   input  wire sample_type             req_sample_4,
   input  wire sample_type             req_sample_5,
   input  wire sample_type             req_sample_6,
   input  wire sample_type             req_sample_7,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [1:0]                  rsp_kind,
   output value_type                   rsp_value_0,
   output value_type                   rsp_value_1,
   output value_type                   rsp_value_2,
   output value_type                   rsp_value_3,
   output value_type                   rsp_value_4,
   output value_type                   rsp_value_5,
   output value_type                   rsp_value_6,
   output value_type                   rsp_value_7,
   output logic [TOTAL_W-1:0]          rsp_weight_sum,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int OFS_CNT_W = $clog2(OFFSET_FRAMES + 1);
   localparam int MAP_CNT_W = $clog2(MAP_FRAMES + 1);

   // configuration
   logic               log_en_ff, log_en_in;
   logic               stream_en_ff, stream_en_in;
   logic [RADIO_W-1:0] radio_div_ff, radio_div_in;

   // sequencer state
   logic [OFS_CNT_W-1:0] ofs_cnt_ff, ofs_cnt_in;
   logic                 ofs_ready_ff, ofs_ready_in;
   logic                 map_active_ff, map_active_in;
   logic [MAP_CNT_W-1:0] map_cnt_ff, map_cnt_in;
   logic [RADIO_W-1:0]   radio_cnt_ff, radio_cnt_in;
   logic [FIN_STEPS-1:0] fin_ff, fin_in;
   logic                 fin_map_ff, fin_map_in;

   logic                 accept;
   logic                 fin_start;
   logic                 frame_push;
   kind_type             frame_kind;
   logic [RADIO_W-1:0]   radio_inc;
   logic [OFS_CNT_W-1:0] ofs_cnt_inc;
   logic [MAP_CNT_W-1:0] map_cnt_inc;
   lane_ctrl_type        ctrl;
   logic                 q_full;

   sample_type                  samples  [MAX_CHANNELS];
   value_type [MAX_CHANNELS-1:0] cal_vals;
   value_type [MAX_CHANNELS-1:0] avg_vals;
   rsp_word_type                rsp_word;

   assign samples[0] = req_sample_0;
   assign samples[1] = req_sample_1;
   assign samples[2] = req_sample_2;
   assign samples[3] = req_sample_3;
   assign samples[4] = req_sample_4;
   assign samples[5] = req_sample_5;
   assign samples[6] = req_sample_6;
   assign samples[7] = req_sample_7;

   // register writes; unknown index is ignored
   assign csr_ready = 1'b1;

   always_comb begin
      log_en_in    = log_en_ff;
      stream_en_in = stream_en_ff;
      radio_div_in = radio_div_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_reg_type'(csr_index))
            REG_LOGGING_ENABLE:   log_en_in    = csr_data[0];
            REG_STREAMING_ENABLE: stream_en_in = csr_data[0];
            REG_RADIO_DIVIDER:    radio_div_in = csr_data;
            default:              ;
         endcase
      end
   end

   // input handshake: held off by the divide sequence or a full queue
   assign req_ready = (fin_ff == '0) && !q_full;
   assign accept    = req_valid && req_ready;

   // per-word sequencing
   always_comb begin
      ofs_cnt_in    = ofs_cnt_ff;
      ofs_ready_in  = ofs_ready_ff;
      map_active_in = map_active_ff;
      map_cnt_in    = map_cnt_ff;
      radio_cnt_in  = radio_cnt_ff;
      fin_map_in    = fin_map_ff;
      fin_start     = 1'b0;
      frame_push    = 1'b0;
      frame_kind    = KIND_LOG;
      ctrl          = '0;
      radio_inc     = radio_cnt_ff + RADIO_W'(1);
      ofs_cnt_inc   = ofs_cnt_ff + OFS_CNT_W'(1);
      map_cnt_inc   = map_cnt_ff + MAP_CNT_W'(1);

      if (accept) begin
         priority if (req_action == ACT_MAP_START) begin
            // (re)start a capture
            map_active_in = 1'b1;
            map_cnt_in    = '0;
            ctrl.map_clr  = 1'b1;
         end else if (map_active_ff) begin
            ctrl.map_acc = 1'b1;
            map_cnt_in   = map_cnt_inc;
            if (map_cnt_inc == MAP_CNT_W'(MAP_FRAMES)) begin
               map_active_in = 1'b0;
               fin_start     = 1'b1;
               fin_map_in    = 1'b1;
            end
         end else if (!ofs_ready_ff) begin
            ctrl.ofs_acc = 1'b1;
            ofs_cnt_in   = ofs_cnt_inc;
            if (ofs_cnt_inc == OFS_CNT_W'(OFFSET_FRAMES)) begin
               ofs_ready_in = 1'b1;
               fin_start    = 1'b1;
               fin_map_in   = 1'b0;
            end
         end else if (log_en_ff || stream_en_ff) begin
            if (log_en_ff) begin
               frame_push = 1'b1;
               frame_kind = KIND_LOG;
            end
            if (stream_en_ff && !log_en_ff) begin
               // decimation for the radio
               if (radio_inc >= radio_div_ff) begin
                  radio_cnt_in = '0;
                  frame_push   = 1'b1;
                  frame_kind   = KIND_RADIO;
               end else begin
                  radio_cnt_in = radio_inc;
               end
            end else begin
               radio_cnt_in = '0;
            end
         end
      end

      // divide sequence steps
      fin_in        = {fin_ff[FIN_STEPS-2:0], fin_start};
      ctrl.div_load = fin_ff[0];
      ctrl.div_mult = fin_ff[1];
      ctrl.div_done = fin_ff[2];
      ctrl.div_map  = fin_map_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log_en_ff     <= 1'b0;
         stream_en_ff  <= 1'b0;
         radio_div_ff  <= RADIO_DIV_RESET;
         ofs_cnt_ff    <= '0;
         ofs_ready_ff  <= 1'b0;
         map_active_ff <= 1'b0;
         map_cnt_ff    <= '0;
         radio_cnt_ff  <= '0;
         fin_ff        <= '0;
         fin_map_ff    <= 1'b0;
      end else begin
         log_en_ff     <= log_en_in;
         stream_en_ff  <= stream_en_in;
         radio_div_ff  <= radio_div_in;
         ofs_cnt_ff    <= ofs_cnt_in;
         ofs_ready_ff  <= ofs_ready_in;
         map_active_ff <= map_active_in;
         map_cnt_ff    <= map_cnt_in;
         radio_cnt_ff  <= radio_cnt_in;
         fin_ff        <= fin_in;
         fin_map_ff    <= fin_map_in;
      end
   end

   // lane array; unused channels read as zero
   for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
      if (c < CHANNELS) begin : g_used
         moc_lane #(
            .OFFSET_FRAMES (OFFSET_FRAMES),
            .MAP_FRAMES    (MAP_FRAMES)
         ) u_lane (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .sample    (samples[c]),
            .cal_value (cal_vals[c]),
            .avg_value (avg_vals[c])
         );
      end else begin : g_unused
         assign cal_vals[c] = '0;
         assign avg_vals[c] = '0;
      end
   end

   moc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .frame_push (frame_push),
      .frame_kind (frame_kind),
      .cal_vals   (cal_vals),
      .map_push   (fin_ff[FIN_STEPS-1] && fin_map_ff),
      .avg_vals   (avg_vals),
      .full       (q_full),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

   assign rsp_kind       = rsp_word.kind;
   assign rsp_value_0    = rsp_word.value[0];
   assign rsp_value_1    = rsp_word.value[1];
   assign rsp_value_2    = rsp_word.value[2];
   assign rsp_value_3    = rsp_word.value[3];
   assign rsp_value_4    = rsp_word.value[4];
   assign rsp_value_5    = rsp_word.value[5];
   assign rsp_value_6    = rsp_word.value[6];
   assign rsp_value_7    = rsp_word.value[7];
   assign rsp_weight_sum = rsp_word.total;

   `MOC_ASSERT_IMPL(a_silent_calibration, clock, reset, accept && !ofs_ready_ff, !frame_push, "word during offset calibration")
   `MOC_ASSERT_ALWAYS(a_fin_single_step, clock, reset, $onehot0(fin_ff), "divide sequence overlap")
   `MOC_ASSERT_NEXT(a_fin_holds_input, clock, reset, fin_start, !req_ready, "input taken during divide")

endmodule

`default_nettype wire
